@@ sv/sensor_block_average_fault_check_assert.svh @@
// Assertion macros for the sensor block average fault check.
// Used by the top level; expects i_clk and i_rst_n in the enclosing scope.
`ifndef SENSOR_BLOCK_AVERAGE_FAULT_CHECK_ASSERT_SVH
`define SENSOR_BLOCK_AVERAGE_FAULT_CHECK_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low
`define SBAFC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbafc assertion failed");
// Next-cycle implication, disabled while reset is low
`define SBAFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbafc assertion failed");
`else
`define SBAFC_ASSERT_NOW(lbl, ante, cons)
`define SBAFC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ sv/sbafc_pkg.sv @@
// Shared constants, types and codes for the sensor block average fault check.
// No dependencies; imported by sbafc_accum and the top level.
`timescale 1ns / 1ps

package sbafc_pkg;

    // Ring geometry
    localparam int DEPTH = 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths
    localparam int SMP_W = 16;
    localparam int PER_W = 16;
    localparam int THR_W = 7;
    localparam int CFG_W = 16;
    localparam int SUM_W = SMP_W + IDX_W;

    // Divisor for the block average
    localparam logic signed [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

    // Register reset values
    localparam logic [PER_W-1:0]        PERIOD_RST = 16'd100;
    localparam logic signed [SMP_W-1:0] BREAK_RST  = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0] SHORT_RST  = 16'sh8000;
    localparam logic [THR_W-1:0]        THR_RST    = 7'd4;
    localparam logic [PER_W-1:0]        TICK_MAX   = 16'hFFFF;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PERIOD = 2'd0,
        CFG_BREAK  = 2'd1,
        CFG_SHORT  = 2'd2,
        CFG_THRESH = 2'd3
    } t_cfg_idx;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } t_state;

    // Accumulator control
    typedef struct packed {
        logic clear;
        logic add;
    } t_acc_ctl;

    // One published result
    typedef struct packed {
        logic signed [SMP_W-1:0] temperature;
        logic                    open_fault;
        logic                    short_fault;
    } t_result;

endpackage

@@ sv/sbafc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sbafc_ram #(
    parameter int DATA_W  = 16,
    parameter int N_WORDS = 8,
    parameter int ADDR_W  = (N_WORDS > 1) ? $clog2(N_WORDS) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [N_WORDS];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/sbafc_accum.sv @@
// Scan accumulator: fault code match counts and wide sum over the ring, plus result select.
// Depends on sbafc_pkg.
`timescale 1ns / 1ps

module sbafc_accum import sbafc_pkg::*; (
    input  logic                    i_clk,
    input  t_acc_ctl                i_ctl,
    input  logic signed [SMP_W-1:0] i_sample,
    input  logic signed [SMP_W-1:0] i_break_code,
    input  logic signed [SMP_W-1:0] i_short_code,
    input  logic [THR_W-1:0]        i_threshold,
    output t_result                 o_result
);

    logic [CNT_W-1:0]        r_cnt_brk;
    logic [CNT_W-1:0]        r_cnt_sht;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]        n_cnt_brk;
    logic [CNT_W-1:0]        n_cnt_sht;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] w_avg;
    logic                    w_open;
    logic                    w_short;

    // Clear at scan start, accumulate one sample per ring read
    always_comb begin
        n_cnt_brk = r_cnt_brk;
        n_cnt_sht = r_cnt_sht;
        n_sum     = r_sum;
        if (i_ctl.clear) begin
            n_cnt_brk = '0;
            n_cnt_sht = '0;
            n_sum     = '0;
        end else if (i_ctl.add) begin
            if (i_sample == i_break_code) begin
                n_cnt_brk = r_cnt_brk + 1'b1;
            end
            if (i_sample == i_short_code) begin
                n_cnt_sht = r_cnt_sht + 1'b1;
            end
            n_sum = r_sum + SUM_W'(i_sample);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt_brk <= n_cnt_brk;
        r_cnt_sht <= n_cnt_sht;
        r_sum     <= n_sum;
    end

    // Average truncates toward zero; short code wins over break code
    always_comb begin
        w_avg   = r_sum / DEPTH_SUM;
        w_open  = THR_W'(r_cnt_brk) >= i_threshold;
        w_short = THR_W'(r_cnt_sht) >= i_threshold;
        o_result.open_fault  = w_open;
        o_result.short_fault = w_short;
        if (w_short) begin
            o_result.temperature = i_short_code;
        end else if (w_open) begin
            o_result.temperature = i_break_code;
        end else begin
            o_result.temperature = $signed(w_avg[SMP_W-1:0]);
        end
    end

endmodule

@@ sv/sensor_block_average_fault_check.sv @@
// Top level of the sensor block average fault check: config registers, tick and ring control.
// Depends on sbafc_pkg, sbafc_ram, sbafc_accum and the assertion macro header.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------------
//   input    | i_in_valid / o_in_ready    | i_reading
//   output   | o_out_valid / i_out_ready  | o_temperature, o_open_fault, o_short_fault
//   config   | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// An item that stores nothing, or stores into a slot other than slot 0, leaves the block ready.
// An item that stores into slot 0 starts a ring scan through the RAM read port: one read
// per slot, and no new item is taken until S_SCAN, S_DRAIN and S_FIN lead back to S_IDLE.
// The result waits in an output register; new items are taken while it waits, and a scan
// that finishes holds in its last step until that register is free.
// Reset is synchronous; ring valid bits clear at once, so no clearing pass is needed.
`timescale 1ns / 1ps
`include "sensor_block_average_fault_check_assert.svh"

module sensor_block_average_fault_check import sbafc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [SMP_W-1:0] i_reading,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [SMP_W-1:0] o_temperature,
    output logic                    o_open_fault,
    output logic                    o_short_fault,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // Configuration
    logic [PER_W-1:0]        r_period;
    logic signed [SMP_W-1:0] r_break;
    logic signed [SMP_W-1:0] r_short;
    logic [THR_W-1:0]        r_thresh;

    // Control state
    logic [PER_W-1:0]        r_tick;
    logic [IDX_W-1:0]        r_widx;
    logic [DEPTH-1:0]        r_vld;
    t_state                  r_state;
    t_state                  n_state;
    logic [IDX_W-1:0]        r_addr;
    logic [IDX_W-1:0]        n_addr;
    logic                    r_rd_pend;
    logic                    r_rd_vbit;
    logic                    r_out_valid;
    t_result                 r_out;

    // Datapath
    logic                    w_in_acc;
    logic [PER_W-1:0]        w_tick_inc;
    logic                    w_store;
    logic                    w_scan_start;
    logic                    w_ram_re;
    logic                    w_load;
    logic [SMP_W-1:0]        w_ram_q;
    logic signed [SMP_W-1:0] w_sample;
    t_acc_ctl                w_acc_ctl;
    t_result                 w_result;

    // Tick counter saturates; a store happens once it reaches the period
    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_tick_inc   = (r_tick != TICK_MAX) ? r_tick + 1'b1 : r_tick;
    assign w_store      = w_tick_inc >= r_period;
    assign w_scan_start = w_in_acc && w_store && (r_widx == '0);

    // Writes only in idle, reads only in scan: the two never touch the ring together
    assign o_in_ready = (r_state == S_IDLE);
    assign w_ram_re   = (r_state == S_SCAN);

    sbafc_ram #(
        .DATA_W  (SMP_W),
        .N_WORDS (DEPTH),
        .ADDR_W  (IDX_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_store),
        .i_waddr (r_widx),
        .i_wdata (i_reading),
        .i_re    (w_ram_re),
        .i_raddr (r_addr),
        .o_rdata (w_ram_q)
    );

    // Slots never written read as zero
    assign w_sample        = r_rd_vbit ? $signed(w_ram_q) : '0;
    assign w_acc_ctl.clear = w_scan_start;
    assign w_acc_ctl.add   = r_rd_pend;

    sbafc_accum u_accum (
        .i_clk        (i_clk),
        .i_ctl        (w_acc_ctl),
        .i_sample     (w_sample),
        .i_break_code (r_break),
        .i_short_code (r_short),
        .i_threshold  (r_thresh),
        .o_result     (w_result)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            r_break  <= BREAK_RST;
            r_short  <= SHORT_RST;
            r_thresh <= THR_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PERIOD: r_period <= i_cfg_data[PER_W-1:0];
                CFG_BREAK:  r_break  <= $signed(i_cfg_data[SMP_W-1:0]);
                CFG_SHORT:  r_short  <= $signed(i_cfg_data[SMP_W-1:0]);
                CFG_THRESH: r_thresh <= i_cfg_data[THR_W-1:0];
                default:    r_period <= r_period;
            endcase
        end
    end

    // Tick counter, write index and ring valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_widx <= '0;
            r_vld  <= '0;
        end else if (w_in_acc) begin
            if (w_store) begin
                r_tick        <= '0;
                r_widx        <= (r_widx == LAST_IDX) ? '0 : r_widx + 1'b1;
                r_vld[r_widx] <= 1'b1;
            end else begin
                r_tick <= w_tick_inc;
            end
        end
    end

    // Scan sequencer: next state and read address
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        w_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_scan_start) begin
                    n_state = S_SCAN;
                    n_addr  = '0;
                end
            end
            S_SCAN: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_addr    <= '0;
            r_rd_pend <= 1'b0;
            r_rd_vbit <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_rd_pend <= w_ram_re;
            r_rd_vbit <= r_vld[r_addr];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_temperature = r_out.temperature;
    assign o_open_fault  = r_out.open_fault;
    assign o_short_fault = r_out.short_fault;

    // Checks
    `SBAFC_ASSERT_NOW(a_no_write_in_scan, r_state != S_IDLE, !w_in_acc)
    `SBAFC_ASSERT_NOW(a_widx_in_range, 1'b1, r_widx <= LAST_IDX)
    `SBAFC_ASSERT_NOW(a_short_wins, o_out_valid && o_short_fault, o_temperature == r_short)
    `SBAFC_ASSERT_NEXT(a_drain_adds, r_state == S_SCAN && r_addr == LAST_IDX,
                       r_state == S_DRAIN && r_rd_pend)

endmodule
